FILE: rtl/wvp_pkg.sv
// Shared constants and types of the window velocity predictor.
// No dependencies; every other file of the block but wvp_ram imports this package.
package wvp_pkg;

  localparam int HISTORY_DEPTH_DEF = 10;
  localparam int POS_W    = 32;
  localparam int STAMP_W  = 48;
  localparam int DT_W     = 24;
  localparam int SPAN_W   = 20;
  localparam int LANES    = 3;
  localparam int DVD_W    = 56;
  localparam int DSR_W    = STAMP_W;
  localparam int US_PER_S = 1000000;
  localparam logic [SPAN_W-1:0] MIN_SPAN_RST = SPAN_W'(1000);

  localparam logic CMD_PUSH  = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  typedef struct packed {
    logic                          cmd;
    logic [LANES-1:0][POS_W-1:0]   pos;
    logic [STAMP_W-1:0]            stamp;
    logic [DT_W-1:0]               predict;
  } item_t;

endpackage

FILE: rtl/window_velocity_predictor.sv
// Top level of the window velocity predictor: front queue plus execution side.
// Depends on wvp_pkg, wvp_front and wvp_back (which uses wvp_ram and wvp_div).
//
// Keeps the most recent HISTORY_DEPTH timestamped 3-D poses (Q16.16 metres,
// microsecond stamps) and answers queries with the average velocity across the
// window and a constant-velocity prediction predict_us ahead, both saturated to
// 32 bits. A push transaction (cmd 0) produces no result. A query transaction
// (cmd 1) over at least two poses passes through these steps once it leaves
// the queue: read the oldest pose from the history RAM, form the span and the
// position differences, load the shared three-lane bit-serial divider, take
// the 56 quotient bits of the division by the window span, saturate the
// velocity, multiply by predict_us, four steps of reciprocal multiplication
// for the division by one million, and add and saturate. With fewer than two
// poses the divider is skipped. The span divider sets the query rate, and the
// next query starts only once the previous result has been taken. A two-entry
// queue sits between the input and the execution side, so new transactions
// are accepted while a query is being worked on, and the result register lets
// the next pushes proceed while a result waits to be taken.
// min_span_us may only be written while the block is idle; zero acts as 1.
module window_velocity_predictor import wvp_pkg::*; #(
  parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [SPAN_W-1:0]  cfg_wdata,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_cmd,
  input  logic [POS_W-1:0]   in_pos_x,
  input  logic [POS_W-1:0]   in_pos_y,
  input  logic [POS_W-1:0]   in_pos_z,
  input  logic [STAMP_W-1:0] in_stamp_us,
  input  logic [DT_W-1:0]    in_predict_us,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [POS_W-1:0]   out_vel_x,
  output logic [POS_W-1:0]   out_vel_y,
  output logic [POS_W-1:0]   out_vel_z,
  output logic [POS_W-1:0]   out_pred_x,
  output logic [POS_W-1:0]   out_pred_y,
  output logic [POS_W-1:0]   out_pred_z,
  output logic               out_has_motion
);

  // Queue hand-off between the accepting side and the execution side.
  logic  q_valid;
  logic  q_pop;
  item_t q_item;

  wvp_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_cmd        (in_cmd),
    .in_pos_x      (in_pos_x),
    .in_pos_y      (in_pos_y),
    .in_pos_z      (in_pos_z),
    .in_stamp_us   (in_stamp_us),
    .in_predict_us (in_predict_us),
    .q_valid       (q_valid),
    .q_item        (q_item),
    .q_pop         (q_pop)
  );

  // The execution side owns the history, the register and the result.
  wvp_back #(.HISTORY_DEPTH(HISTORY_DEPTH)) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .q_valid        (q_valid),
    .q_item         (q_item),
    .q_pop          (q_pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_vel_x      (out_vel_x),
    .out_vel_y      (out_vel_y),
    .out_vel_z      (out_vel_z),
    .out_pred_x     (out_pred_x),
    .out_pred_y     (out_pred_y),
    .out_pred_z     (out_pred_z),
    .out_has_motion (out_has_motion)
  );

endmodule

FILE: rtl/wvp_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module wvp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/wvp_front.sv
// Input side: accepts transactions, packs them into items and queues them.
// Depends on wvp_pkg.
module wvp_front import wvp_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_cmd,
  input  logic [POS_W-1:0]   in_pos_x,
  input  logic [POS_W-1:0]   in_pos_y,
  input  logic [POS_W-1:0]   in_pos_z,
  input  logic [STAMP_W-1:0] in_stamp_us,
  input  logic [DT_W-1:0]    in_predict_us,
  output logic               q_valid,
  output item_t              q_item,
  input  logic               q_pop
);

  item_t      slot_r [2];
  logic       wr_r, rd_r;
  logic [1:0] cnt_r;
  logic       push;
  item_t      item;

  // Classify the transaction: the command selects which fields matter later.
  always_comb begin
    item.cmd     = in_cmd;
    item.pos     = {in_pos_z, in_pos_y, in_pos_x};
    item.stamp   = in_stamp_us;
    item.predict = in_predict_us;
  end

  assign in_stall = (cnt_r == 2'd2);
  assign push     = in_valid && !in_stall;
  assign q_valid  = (cnt_r != 2'd0);
  assign q_item   = slot_r[rd_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= 1'b0;
      rd_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) begin
        slot_r[wr_r] <= item;
        wr_r         <= !wr_r;
      end
      if (q_pop) begin
        rd_r <= !rd_r;
      end
      cnt_r <= cnt_r + 2'(push) - 2'(q_pop);
    end
  end

endmodule

FILE: rtl/wvp_div.sv
// Three-lane restoring divider sharing one divisor, one quotient bit per cycle.
// Depends on wvp_pkg.
module wvp_div import wvp_pkg::*; (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [LANES-1:0][DVD_W-1:0] dvd,
  input  logic [DSR_W-1:0]            dsr,
  output logic                        done,
  output logic [LANES-1:0][DVD_W-1:0] quo
);

  localparam int CNT_W = $clog2(DVD_W);

  logic                        busy_r, done_r;
  logic [CNT_W-1:0]            cnt_r;
  logic [DSR_W-1:0]            dsr_r;
  logic [LANES-1:0][DVD_W-1:0] quo_r, quo_nxt;
  logic [LANES-1:0][DSR_W-1:0] rem_r, rem_nxt;
  logic [LANES-1:0][DSR_W:0]   rem_sh;

  always_comb begin
    for (int k = 0; k < LANES; k++) begin
      rem_sh[k] = {rem_r[k], quo_r[k][DVD_W-1]};
      if (rem_sh[k] >= {1'b0, dsr_r}) begin
        rem_nxt[k] = DSR_W'(rem_sh[k] - {1'b0, dsr_r});
        quo_nxt[k] = {quo_r[k][DVD_W-2:0], 1'b1};
      end else begin
        rem_nxt[k] = rem_sh[k][DSR_W-1:0];
        quo_nxt[k] = {quo_r[k][DVD_W-2:0], 1'b0};
      end
    end
  end

  assign done = done_r;
  assign quo  = quo_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && !start && (cnt_r == CNT_W'(DVD_W - 1));
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        dsr_r  <= dsr;
        quo_r  <= dvd;
        rem_r  <= '0;
      end else if (busy_r) begin
        quo_r <= quo_nxt;
        rem_r <= rem_nxt;
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(DVD_W - 1)) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

endmodule

FILE: rtl/wvp_back.sv
// Execution side: pose history, span and velocity sequencer, result register.
// Depends on wvp_pkg, wvp_ram and wvp_div.
module wvp_back import wvp_pkg::*; #(
  parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [SPAN_W-1:0]  cfg_wdata,
  input  logic               q_valid,
  input  item_t              q_item,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [POS_W-1:0]   out_vel_x,
  output logic [POS_W-1:0]   out_vel_y,
  output logic [POS_W-1:0]   out_vel_z,
  output logic [POS_W-1:0]   out_pred_x,
  output logic [POS_W-1:0]   out_pred_y,
  output logic [POS_W-1:0]   out_pred_z,
  output logic               out_has_motion
);

  localparam int AW    = $clog2(HISTORY_DEPTH);
  localparam int CW    = $clog2(HISTORY_DEPTH + 1);
  localparam int SW    = CW + 1;
  localparam int RAM_W = LANES * POS_W + STAMP_W;
  // One million is 64 * 15625: the product is shifted right by 6 and then
  // multiplied by ceil(2^63 / 15625), which gives the exact floor quotient.
  localparam int ACC_W    = 100;
  localparam int RECIP_SH = 63;
  localparam logic [63:0] RECIP = (64'h8000000000000000 / 64'd15625) + 64'd1;

  typedef enum logic [2:0] {
    S_IDLE, S_READ, S_PREP, S_DIV1, S_PMUL, S_RECIP, S_SUM
  } state_t;

  state_t                      state_r;
  logic [SPAN_W-1:0]           min_span_r;
  logic [AW-1:0]               oldest_r;
  logic [CW-1:0]               fill_r;
  logic [LANES-1:0][POS_W-1:0] newest_pos_r;
  logic [STAMP_W-1:0]          newest_stamp_r;
  logic [DT_W-1:0]             dt_r;
  logic [DSR_W-1:0]            span_r;
  logic [LANES-1:0][POS_W:0]   dmag_r;
  logic [LANES-1:0]            dneg_r;
  logic [LANES-1:0][POS_W-1:0] vel_r, pred_r;
  logic [LANES-1:0]            vneg_r;
  logic                        out_valid_r, has_motion_r;
  logic [LANES-1:0][DVD_W-1:0] div_dvd_r;
  logic [DSR_W-1:0]            div_dsr_r;
  logic                        div_start_r;
  logic                        div_done;
  logic [LANES-1:0][DVD_W-1:0] div_quo;
  logic [LANES-1:0][DVD_W-1:0] prod_r;
  logic [LANES-1:0][ACC_W-1:0] acc_r;
  logic [1:0]                  pp_r;

  logic                        ram_we;
  logic [AW-1:0]               wslot;
  logic [SW-1:0]               slot_sum;
  logic [RAM_W-1:0]            ram_rdata;
  logic [LANES-1:0][POS_W-1:0] old_pos;
  logic [STAMP_W-1:0]          old_stamp;
  logic                        is_push;

  logic signed [STAMP_W:0]     span_raw, span_floor;
  logic [LANES-1:0][POS_W:0]   diff;
  logic [LANES-1:0][POS_W-1:0] vmag;
  logic [LANES-1:0][37:0]      sum38;
  logic [LANES-1:0][31:0]      pp_a;
  logic [31:0]                 pp_b;
  logic [LANES-1:0][63:0]      pp;
  logic [LANES-1:0][ACC_W-1:0] pp_sh;

  function automatic logic [POS_W-1:0] sat_mag(input logic neg, input logic [DVD_W-1:0] mag);
    logic [POS_W-1:0] r;
    if (!neg) begin
      r = (mag > DVD_W'(32'h7fffffff)) ? 32'h7fffffff : mag[POS_W-1:0];
    end else begin
      r = (mag > DVD_W'(33'h80000000)) ? 32'h80000000 : (~mag[POS_W-1:0] + 1'b1);
    end
    return r;
  endfunction

  function automatic logic [POS_W-1:0] sat_sum(input logic [37:0] v);
    logic [POS_W-1:0] r;
    if (!v[37] && (v[36:31] != 6'b0)) begin
      r = 32'h7fffffff;
    end else if (v[37] && (v[36:31] != 6'h3f)) begin
      r = 32'h80000000;
    end else begin
      r = v[POS_W-1:0];
    end
    return r;
  endfunction

  assign is_push = (q_item.cmd == CMD_PUSH);
  assign q_pop   = (state_r == S_IDLE) && q_valid && (is_push || !out_valid_r);
  assign ram_we  = q_pop && is_push;

  // Slot for a push: behind the newest entry, or over the oldest when full.
  always_comb begin
    slot_sum = SW'(oldest_r) + SW'(fill_r);
    if (slot_sum >= SW'(HISTORY_DEPTH)) begin
      slot_sum = slot_sum - SW'(HISTORY_DEPTH);
    end
    wslot = (fill_r < CW'(HISTORY_DEPTH)) ? slot_sum[AW-1:0] : oldest_r;
  end

  wvp_ram #(.WIDTH(RAM_W), .DEPTH(HISTORY_DEPTH)) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wslot),
    .wdata ({q_item.pos, q_item.stamp}),
    .raddr (oldest_r),
    .rdata (ram_rdata)
  );

  assign old_pos   = ram_rdata[RAM_W-1:STAMP_W];
  assign old_stamp = ram_rdata[STAMP_W-1:0];

  always_comb begin
    span_raw   = $signed({1'b0, newest_stamp_r}) - $signed({1'b0, old_stamp});
    span_floor = (min_span_r == '0) ? (STAMP_W+1)'(1) : (STAMP_W+1)'(min_span_r);
    for (int k = 0; k < LANES; k++) begin
      diff[k] = {newest_pos_r[k][POS_W-1], newest_pos_r[k]}
              - {old_pos[k][POS_W-1], old_pos[k]};
      vmag[k] = vel_r[k][POS_W-1] ? (~vel_r[k] + 1'b1) : vel_r[k];
    end
  end

  wvp_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start_r),
    .dvd   (div_dvd_r),
    .dsr   (div_dsr_r),
    .done  (div_done),
    .quo   (div_quo)
  );

  // One 32 by 32 partial product per lane and cycle; pp_r picks the halves.
  always_comb begin
    pp_b = pp_r[1] ? RECIP[63:32] : RECIP[31:0];
    for (int k = 0; k < LANES; k++) begin
      pp_a[k] = pp_r[0] ? 32'(prod_r[k][DVD_W-1:38]) : prod_r[k][37:6];
      pp[k]   = 64'(pp_a[k]) * 64'(pp_b);
      case (pp_r)
        2'd0:    pp_sh[k] = ACC_W'(pp[k]);
        2'd3:    pp_sh[k] = ACC_W'({pp[k], 64'b0});
        default: pp_sh[k] = ACC_W'({pp[k], 32'b0});
      endcase
    end
  end

  always_comb begin
    for (int k = 0; k < LANES; k++) begin
      logic [37:0] step;
      step = vneg_r[k] ? -{1'b0, acc_r[k][ACC_W-1:RECIP_SH]}
                       : {1'b0, acc_r[k][ACC_W-1:RECIP_SH]};
      sum38[k] = {{6{newest_pos_r[k][POS_W-1]}}, newest_pos_r[k]} + step;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      min_span_r  <= MIN_SPAN_RST;
      oldest_r    <= '0;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
      div_start_r <= 1'b0;
      pp_r        <= '0;
    end else begin
      div_start_r <= (state_r == S_PREP) && (fill_r >= CW'(2));
      out_valid_r <= out_valid_r ? out_stall : (state_r == S_SUM);
      if (cfg_we) begin
        min_span_r <= cfg_wdata;
      end
      case (state_r)
        S_IDLE: begin
          if (q_pop && is_push) begin
            if (fill_r < CW'(HISTORY_DEPTH)) begin
              fill_r <= fill_r + 1'b1;
            end else begin
              oldest_r <= (oldest_r == AW'(HISTORY_DEPTH - 1)) ? '0 : oldest_r + 1'b1;
            end
            newest_pos_r   <= q_item.pos;
            newest_stamp_r <= q_item.stamp;
          end else if (q_pop) begin
            dt_r    <= q_item.predict;
            state_r <= S_READ;
          end
        end
        S_READ: begin
          span_r <= (span_raw < span_floor) ? span_floor[STAMP_W-1:0] : span_raw[STAMP_W-1:0];
          for (int k = 0; k < LANES; k++) begin
            dneg_r[k] <= diff[k][POS_W];
            dmag_r[k] <= diff[k][POS_W] ? (~diff[k] + 1'b1) : diff[k];
          end
          state_r <= S_PREP;
        end
        S_PREP: begin
          has_motion_r <= (fill_r >= CW'(2));
          if (fill_r >= CW'(2)) begin
            for (int k = 0; k < LANES; k++) begin
              div_dvd_r[k] <= DVD_W'(DVD_W'(dmag_r[k]) * DVD_W'(US_PER_S));
            end
            div_dsr_r <= span_r;
            state_r   <= S_DIV1;
          end else begin
            vel_r   <= '0;
            state_r <= S_PMUL;
          end
        end
        S_DIV1: begin
          if (div_done) begin
            for (int k = 0; k < LANES; k++) begin
              vel_r[k] <= sat_mag(dneg_r[k], div_quo[k]);
            end
            state_r <= S_PMUL;
          end
        end
        S_PMUL: begin
          for (int k = 0; k < LANES; k++) begin
            vneg_r[k] <= vel_r[k][POS_W-1];
            prod_r[k] <= DVD_W'(vmag[k]) * DVD_W'(dt_r);
          end
          acc_r   <= '0;
          pp_r    <= '0;
          state_r <= S_RECIP;
        end
        S_RECIP: begin
          for (int k = 0; k < LANES; k++) begin
            acc_r[k] <= acc_r[k] + pp_sh[k];
          end
          pp_r <= pp_r + 1'b1;
          if (pp_r == 2'd3) begin
            state_r <= S_SUM;
          end
        end
        S_SUM: begin
          for (int k = 0; k < LANES; k++) begin
            pred_r[k] <= (fill_r == '0) ? '0 : sat_sum(sum38[k]);
          end
          state_r <= S_IDLE;
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid      = out_valid_r;
  assign out_vel_x      = vel_r[0];
  assign out_vel_y      = vel_r[1];
  assign out_vel_z      = vel_r[2];
  assign out_pred_x     = pred_r[0];
  assign out_pred_y     = pred_r[1];
  assign out_pred_z     = pred_r[2];
  assign out_has_motion = has_motion_r;

endmodule

FILE: tb/window_velocity_predictor_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench of window_velocity_predictor: directed table plus random traffic.
// Depends on wvp_pkg and the RTL of the block; contains its own pose-history predictor.
module window_velocity_predictor_tb;
  import wvp_pkg::*;

  localparam int DEPTH = HISTORY_DEPTH_DEF;
  localparam int N_PHASES = 5;
  localparam int ITEMS_PER_PHASE = 250;
  localparam int DRAIN_CYCLES = 200;
  localparam int EST_SLOTS = 2048;
  localparam int ROW_SLOTS = 64;

  logic               clk;
  logic               rst_n;
  logic               cfg_we;
  logic [SPAN_W-1:0]  cfg_wdata;
  logic               in_valid;
  logic               in_stall;
  logic               in_cmd;
  logic [POS_W-1:0]   in_pos_x;
  logic [POS_W-1:0]   in_pos_y;
  logic [POS_W-1:0]   in_pos_z;
  logic [STAMP_W-1:0] in_stamp_us;
  logic [DT_W-1:0]    in_predict_us;
  logic               out_valid;
  logic               out_stall;
  logic [POS_W-1:0]   out_vel_x;
  logic [POS_W-1:0]   out_vel_y;
  logic [POS_W-1:0]   out_vel_z;
  logic [POS_W-1:0]   out_pred_x;
  logic [POS_W-1:0]   out_pred_y;
  logic [POS_W-1:0]   out_pred_z;
  logic               out_has_motion;

  window_velocity_predictor dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_stall(in_stall), .in_cmd(in_cmd),
    .in_pos_x(in_pos_x), .in_pos_y(in_pos_y), .in_pos_z(in_pos_z),
    .in_stamp_us(in_stamp_us), .in_predict_us(in_predict_us),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_vel_x(out_vel_x), .out_vel_y(out_vel_y), .out_vel_z(out_vel_z),
    .out_pred_x(out_pred_x), .out_pred_y(out_pred_y), .out_pred_z(out_pred_z),
    .out_has_motion(out_has_motion)
  );

  // One estimate: velocity and prediction per axis, plus the motion flag.
  typedef struct {
    logic [POS_W-1:0] vel [3];
    logic [POS_W-1:0] pred [3];
    logic             motion;
  } estimate_t;

  // One input transaction; typed rows carry an estimate written by hand.
  typedef struct {
    logic               cmd;
    logic [POS_W-1:0]   pos [3];
    logic [STAMP_W-1:0] stamp;
    logic [DT_W-1:0]    dt;
    bit                 typed;
    estimate_t          est;
  } pose_txn_t;

  // Predictor copy of the block state: the pose window and the span floor.
  logic signed [POS_W-1:0] win_pos [DEPTH][3];
  logic [STAMP_W-1:0]      win_stamp [DEPTH];
  int                      win_oldest;
  int                      win_fill;
  logic [SPAN_W-1:0]       span_floor_reg;

  // Expected estimates in order; est_wr and est_rd only ever count up.
  estimate_t est_fifo [EST_SLOTS];
  int        est_wr;
  int        est_rd;
  pose_txn_t directed_rows [ROW_SLOTS];
  int        n_rows;
  int        mismatches;
  bit        pressure_go;
  int        quiet_left;

  initial clk = 1'b0;
  always #2 clk = ~clk;

  // The run is far shorter than this even with every stall at its longest.
  initial begin
    #4_000_000;
    $display("Some tests failed");
    $finish;
  end

  function automatic logic [POS_W-1:0] clip32(input longint v);
    if (v > longint'(32'sh7fffffff)) return 32'h7fffffff;
    if (v < -longint'(64'sh80000000)) return 32'h80000000;
    return v[POS_W-1:0];
  endfunction

  // Velocity is (newest - oldest) * 1e6 / span with span clamped below by the
  // register (zero acts as one); prediction adds velocity * dt / 1e6.
  function automatic estimate_t window_estimate(input logic [DT_W-1:0] dt);
    estimate_t e;
    longint vel [3];
    longint span, lo, d, step;
    int nw;
    for (int k = 0; k < 3; k++) begin
      vel[k] = 0;
      e.vel[k] = '0;
      e.pred[k] = '0;
    end
    e.motion = (win_fill >= 2);
    nw = (win_oldest + win_fill - 1) % DEPTH;
    if (win_fill >= 2) begin
      span = longint'({16'b0, win_stamp[nw]}) - longint'({16'b0, win_stamp[win_oldest]});
      lo = (span_floor_reg == 0) ? 1 : longint'({44'b0, span_floor_reg});
      if (span < lo) span = lo;
      for (int k = 0; k < 3; k++) begin
        d = longint'(win_pos[nw][k]) - longint'(win_pos[win_oldest][k]);
        e.vel[k] = clip32((d * 1000000) / span);
        vel[k] = longint'($signed(e.vel[k]));
      end
    end
    if (win_fill >= 1) begin
      for (int k = 0; k < 3; k++) begin
        step = (vel[k] * longint'({40'b0, dt})) / 1000000;
        e.pred[k] = clip32(longint'(win_pos[nw][k]) + step);
      end
    end
    return e;
  endfunction

  // Apply an accepted transaction to the predictor state.
  function automatic void absorb_txn(input pose_txn_t t);
    int slot;
    if (t.cmd == CMD_PUSH) begin
      if (win_fill < DEPTH) begin
        slot = (win_oldest + win_fill) % DEPTH;
        win_fill++;
      end else begin
        slot = win_oldest;
        win_oldest = (win_oldest + 1) % DEPTH;
      end
      for (int k = 0; k < 3; k++) win_pos[slot][k] = t.pos[k];
      win_stamp[slot] = t.stamp;
    end else if (t.typed) begin
      est_fifo[est_wr] = t.est;
      est_wr++;
    end else begin
      est_fifo[est_wr] = window_estimate(t.dt);
      est_wr++;
    end
  endfunction

  function automatic int pick_gap();
    int r;
    if (quiet_left > 0) begin
      quiet_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) quiet_left = $urandom_range(20, 60);
    if (r < 55) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Drive one transaction and hold it until the block takes it.
  task automatic send_txn(input pose_txn_t t);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_cmd        <= t.cmd;
    in_pos_x      <= t.pos[0];
    in_pos_y      <= t.pos[1];
    in_pos_z      <= t.pos[2];
    in_stamp_us   <= t.stamp;
    in_predict_us <= t.dt;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    absorb_txn(t);
  endtask

  task automatic add_row(input logic cmd, input logic [31:0] x, input logic [31:0] y,
                         input logic [31:0] z, input logic [47:0] st, input logic [23:0] dt,
                         input bit typed, input estimate_t est);
    pose_txn_t t;
    t.cmd = cmd;
    t.pos[0] = x;
    t.pos[1] = y;
    t.pos[2] = z;
    t.stamp = st;
    t.dt = dt;
    t.typed = typed;
    t.est = est;
    directed_rows[n_rows] = t;
    n_rows++;
  endtask

  // Wait until every estimate has come back and any trailing push has retired.
  task automatic drain();
    while (est_wr != est_rd) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Result-side stall: random bursts, quiet stretches, and one long hold-off
  // that lets the internal queue fill so the input channel stalls too.
  initial begin
    int burst;
    int hold_left;
    burst = 0;
    hold_left = 0;
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (pressure_go) begin
        pressure_go = 1'b0;
        hold_left = 600;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (burst > 0) begin
        burst--;
      end else begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3: begin
            out_stall <= 1'b0;
            burst = $urandom_range(1, 6);
          end
          4, 5, 6: begin
            out_stall <= 1'b1;
            burst = $urandom_range(0, 3);
          end
          7: begin
            out_stall <= 1'b1;
            burst = $urandom_range(20, 150);
          end
          default: begin
            out_stall <= 1'b0;
            burst = $urandom_range(50, 200);
          end
        endcase
      end
    end
  end

  // Compare every accepted result transaction with the oldest estimate.
  always @(posedge clk) begin
    estimate_t want;
    logic [POS_W-1:0] got [6];
    if (rst_n && out_valid && !out_stall) begin
      got[0] = out_vel_x;
      got[1] = out_vel_y;
      got[2] = out_vel_z;
      got[3] = out_pred_x;
      got[4] = out_pred_y;
      got[5] = out_pred_z;
      if (est_wr == est_rd) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result transaction at %0t", $realtime);
      end else begin
        want = est_fifo[est_rd];
        est_rd++;
        for (int k = 0; k < 6; k++) begin
          if (got[k] !== (k < 3 ? want.vel[k] : want.pred[k - 3])) begin
            mismatches++;
            if (mismatches <= 10)
              $display("field %0d mismatch: expected %h, got %h", k,
                       (k < 3 ? want.vel[k] : want.pred[k - 3]), got[k]);
          end
        end
        if (out_has_motion !== want.motion) begin
          mismatches++;
          if (mismatches <= 10)
            $display("has_motion mismatch: expected %b, got %b", want.motion, out_has_motion);
        end
      end
    end
  end

  initial begin
    estimate_t zero_est, pose_est, none;
    pose_txn_t t;
    logic [SPAN_W-1:0] floors [N_PHASES];
    logic signed [POS_W-1:0] track [3];
    logic [STAMP_W-1:0] track_stamp;
    int r;

    mismatches = 0;
    quiet_left = 0;
    pressure_go = 1'b0;
    n_rows = 0;
    est_wr = 0;
    est_rd = 0;
    win_oldest = 0;
    win_fill = 0;
    span_floor_reg = MIN_SPAN_RST;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    in_valid = 1'b0;
    in_cmd = CMD_PUSH;
    in_pos_x = '0;
    in_pos_y = '0;
    in_pos_z = '0;
    in_stamp_us = '0;
    in_predict_us = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Hand-written estimates: an empty window gives all zeros, and a single
    // pose predicts itself whatever the look-ahead.
    for (int k = 0; k < 3; k++) begin
      zero_est.vel[k] = '0;
      zero_est.pred[k] = '0;
      pose_est.vel[k] = '0;
    end
    zero_est.motion = 1'b0;
    none = zero_est;
    pose_est.pred[0] = 32'h7fffffff;
    pose_est.pred[1] = 32'h80000000;
    pose_est.pred[2] = 32'h00000000;
    pose_est.motion = 1'b0;

    add_row(CMD_QUERY, '1, '1, '1, '1, 24'hffffff, 1, zero_est);
    add_row(CMD_PUSH, 32'h7fffffff, 32'h80000000, 32'h0, 48'h0, 24'hffffff, 0, none);
    // Push fields on a query are ignored.
    add_row(CMD_QUERY, '1, '1, '1, '1, 24'hffffff, 1, pose_est);
    add_row(CMD_QUERY, '0, '0, '0, '0, 24'h0, 1, pose_est);
    // Opposite extremes one microsecond later: span is clamped, velocity saturates.
    add_row(CMD_PUSH, 32'h80000000, 32'h7fffffff, 32'h12345678, 48'h1, 24'h0, 0, none);
    add_row(CMD_QUERY, '0, '0, '0, '0, 24'hffffff, 0, none);
    add_row(CMD_QUERY, '0, '0, '0, '0, 24'h0, 0, none);
    add_row(CMD_PUSH, 32'h0, 32'h0, 32'h0, 48'hffffffffffff, 24'h123456, 0, none);
    add_row(CMD_QUERY, '0, '0, '0, '0, 24'd1000000, 0, none);
    // Stamp going backwards relative to the previous pose.
    add_row(CMD_PUSH, 32'h00010000, 32'hffff0000, 32'h1, 48'h5, 24'h0, 0, none);
    add_row(CMD_QUERY, '0, '0, '0, '0, 24'd500000, 0, none);
    // A steady ramp that wraps the window.
    for (int i = 0; i < 12; i++)
      add_row(CMD_PUSH, 32'(i * 32'h10000), 32'(-i * 32'h8000), 32'(i * 3),
              48'(1000000 + i * 100000), 24'h0, 0, none);
    add_row(CMD_QUERY, '0, '0, '0, '0, 24'd250000, 0, none);
    add_row(CMD_QUERY, '0, '0, '0, '0, 24'hffffff, 0, none);

    for (int i = 0; i < n_rows; i++) send_txn(directed_rows[i]);

    floors[0] = 20'd1;
    floors[1] = 20'd1000000;
    floors[2] = 20'd0;
    floors[3] = 20'hfffff;
    floors[4] = 20'($urandom_range(1, 5000));
    for (int k = 0; k < 3; k++) track[k] = win_pos[(win_oldest + win_fill - 1) % DEPTH][k];
    track_stamp = win_stamp[(win_oldest + win_fill - 1) % DEPTH];

    for (int ph = 0; ph < N_PHASES; ph++) begin
      // The register is only written with the block idle.
      in_valid <= 1'b0;
      drain();
      cfg_we <= 1'b1;
      cfg_wdata <= floors[ph];
      @(posedge clk);
      cfg_we <= 1'b0;
      span_floor_reg = floors[ph];
      if (ph == 0) pressure_go = 1'b1;

      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        r = $urandom_range(0, 99);
        t.typed = 0;
        t.est = none;
        for (int k = 0; k < 3; k++) t.pos[k] = $urandom;
        t.stamp = 48'({$urandom, $urandom});
        t.dt = DT_W'($urandom);
        if (r < 55) begin
          // Plausible motion: small steps in position, forward stamps.
          t.cmd = CMD_PUSH;
          for (int k = 0; k < 3; k++) begin
            track[k] = track[k] + ($signed(32'($urandom_range(0, 262144))) - 131072);
            t.pos[k] = track[k];
          end
          track_stamp = track_stamp + $urandom_range(1, 200000);
          t.stamp = track_stamp;
        end else if (r < 65) begin
          // Noise: arbitrary positions and stamps, often backwards in time.
          t.cmd = CMD_PUSH;
          for (int k = 0; k < 3; k++) track[k] = t.pos[k];
          track_stamp = t.stamp;
        end else begin
          t.cmd = CMD_QUERY;
          if ($urandom_range(0, 1) == 0) t.dt = DT_W'($urandom_range(0, 200000));
        end
        send_txn(t);
      end
    end

    in_valid <= 1'b0;
    drain();
    if (mismatches == 0 && est_wr == est_rd) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

FILE: window_velocity_predictor.f
rtl/wvp_pkg.sv
rtl/wvp_ram.sv
rtl/wvp_front.sv
rtl/wvp_div.sv
rtl/wvp_back.sv
rtl/window_velocity_predictor.sv
tb/window_velocity_predictor_tb.sv
